// ===== rtl/dfgw_pkg.sv =====
// Shared types and constants for the deformation graph point warp block.
package dfgw_pkg;

   localparam int NODE_COUNT_DEF = 1024;
   localparam int NODE_WORDS     = 15;
   localparam int GLOBAL_WORDS   = 12;
   localparam int MUL_A_W        = 34;
   localparam int MUL_B_W        = 41;
   localparam int MUL_P_W        = MUL_A_W + MUL_B_W;

   localparam logic [31:0] ONE_Q428 = 32'h1000_0000;

   typedef enum logic [1:0] {
      CMD_NODE_WORD   = 2'd0,
      CMD_GLOBAL_WORD = 2'd1,
      CMD_TERM        = 2'd2,
      CMD_PASS        = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TERM,
      ST_WEIGHT,
      ST_ROUND,
      ST_GLOBAL,
      ST_SAT,
      ST_EMIT
   } state_type;

   // operand bundle into the shared multiplier
   typedef struct packed {
      logic                      valid;
      logic [1:0]                row;
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
   } mul_op_type;

   // registered product out of the shared multiplier
   typedef struct packed {
      logic                      valid;
      logic [1:0]                row;
      logic signed [MUL_P_W-1:0] prod;
   } mul_res_type;

endpackage

// ===== rtl/dfgw_node_mem.sv =====
// Node word memory: one write port, one registered read port.
module dfgw_node_mem #(
   parameter int DEPTH = dfgw_pkg::NODE_COUNT_DEF * dfgw_pkg::NODE_WORDS,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0] mem_ff [DEPTH];
   logic [31:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/dfgw_mul.sv =====
// Shared signed multiplier with a registered product and row tag.
module dfgw_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  dfgw_pkg::mul_op_type op,
   output dfgw_pkg::mul_res_type res
);

   logic                               valid_ff;
   logic [1:0]                         row_ff;
   logic signed [dfgw_pkg::MUL_P_W-1:0] prod_ff;

   // tag valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= op.valid;
      end
   end

   // product
   always_ff @(posedge clock) begin
      if (op.valid) begin
         row_ff  <= op.row;
         prod_ff <= dfgw_pkg::MUL_P_W'(op.a) * dfgw_pkg::MUL_P_W'(op.b);
      end
   end

   assign res.valid = valid_ff;
   assign res.row   = row_ff;
   assign res.prod  = prod_ff;

endmodule

// ===== rtl/deform_graph_point_warp.sv =====
// Top level: point warp through an embedded deformation graph.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | command, node, word, point, weight, last
//  rsp     | out       | rsp_valid/rsp_stall  | out_x/y/z, deformed
//  csr     | in        | csr_wr_en            | apply_global
//
// A word write leaves the sequencer in idle; a point without neighbors goes straight
// to the emit step. A neighbor term makes 15 node word reads from the single memory
// port and drains the pipeline, then does three weight multiplies, all on one shared
// multiplier. A last term then rounds the blend and applies the global transform
// when it is enabled.
// Reset is synchronous; global matrix returns to identity, accumulators clear.
// A held result stalls only the emit step; requests are taken in idle only.
module deform_graph_point_warp #(
   parameter int NODE_COUNT = dfgw_pkg::NODE_COUNT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic [9:0]         req_node_index,
   input  logic [3:0]         req_word_select,
   input  logic signed [31:0] req_word_value,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic [16:0]        req_weight,
   input  logic               req_last_term,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic               rsp_deformed
);

   localparam int DEPTH = NODE_COUNT * dfgw_pkg::NODE_WORDS;
   localparam int AW    = $clog2(DEPTH);
   localparam int AW_B  = dfgw_pkg::MUL_A_W;
   localparam int BW    = dfgw_pkg::MUL_B_W;
   localparam int PW    = dfgw_pkg::MUL_P_W;

   // helpers
   function automatic logic signed [47:0] rnd28(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] s;
      s = p >>> 28;
      return 48'(s) + 48'(p[27]);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
      if (v > 49'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -49'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return 32'(v);
   endfunction

   function automatic logic [1:0] row_of(input logic [3:0] s);
      logic [1:0] r;
      case (s)
         4'd0, 4'd1, 4'd2: r = 2'd0;
         4'd3, 4'd4, 4'd5: r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] col_of(input logic [3:0] s);
      logic [3:0] c;
      c = s - 4'(3 * row_of(s));
      return c[1:0];
   endfunction

   dfgw_pkg::state_type state_ff, state_in;
   logic [4:0]          step_ff, step_in;

   logic                apply_ff;
   logic [31:0]         glob_ff [dfgw_pkg::GLOBAL_WORDS];
   logic signed [63:0]  acc_ff [3];
   logic signed [31:0]  pt_ff [3];
   logic signed [31:0]  g_ff [3];
   logic signed [32:0]  d_ff [3];
   logic signed [BW-1:0] u_ff [3];
   logic signed [BW-1:0] q_ff [3];
   logic signed [31:0]  b_ff [3];
   logic [16:0]         w_ff;
   logic                last_ff;
   logic [AW-1:0]       base_ff;
   logic signed [31:0]  res_ff [3];
   logic                res_def_ff;

   logic                rd_vld_ff;
   logic [3:0]          rd_ord_ff;
   logic [31:0]         rd_data;
   logic                rd_en;
   logic [3:0]          rd_ord;
   logic [AW-1:0]       rd_addr;
   logic [1:0]          g_idx;
   logic [1:0]          t_idx;

   logic                rsp_valid_ff;
   logic signed [31:0]  rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                rsp_def_ff;

   dfgw_pkg::mul_op_type  mop;
   dfgw_pkg::mul_res_type mres;

   logic                accept;
   logic                node_ok;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [AW-1:0]       req_base;
   logic                out_free;
   logic                emit_load;
   logic signed [47:0]  rp;
   logic [3:0]          st4;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != dfgw_pkg::ST_IDLE);
   assign node_ok   = (32'(req_node_index) < NODE_COUNT);
   assign req_base  = AW'(32'(req_node_index) * 32'(dfgw_pkg::NODE_WORDS));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_load = (state_ff == dfgw_pkg::ST_EMIT) && out_free;
   assign st4       = step_ff[3:0];
   assign rp        = rnd28(mres.prod);

   // node memory: word writes in idle, term reads g, t then A
   assign wr_en   = accept && (dfgw_pkg::cmd_type'(req_command) == dfgw_pkg::CMD_NODE_WORD)
                    && node_ok && (req_word_select < 4'(dfgw_pkg::NODE_WORDS));
   assign wr_addr = req_base + AW'(req_word_select);
   assign rd_en   = (state_ff == dfgw_pkg::ST_TERM) && (step_ff < 5'd15);
   assign rd_ord  = (step_ff < 5'd6) ? (st4 + 4'd9) : (st4 - 4'd6);
   assign rd_addr = base_ff + AW'(rd_ord);

   // vector lane of a returning g word (9..11) or t word (12..14)
   assign g_idx = rd_ord_ff[1:0] - 2'd1;
   assign t_idx = rd_ord_ff[1:0];

   dfgw_node_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_word_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // operand select for the shared multiplier
   always_comb begin
      mop = '0;
      case (state_ff)
         dfgw_pkg::ST_TERM: begin
            mop.valid = rd_vld_ff && (rd_ord_ff < 4'd9);
            mop.row   = row_of(rd_ord_ff);
            mop.a     = AW_B'(signed'(rd_data));
            mop.b     = BW'(d_ff[col_of(rd_ord_ff)]);
         end
         dfgw_pkg::ST_WEIGHT: begin
            mop.valid = (step_ff < 5'd3);
            mop.row   = step_ff[1:0];
            mop.a     = AW_B'(w_ff);
            mop.b     = u_ff[step_ff[1:0]];
         end
         dfgw_pkg::ST_GLOBAL: begin
            mop.valid = (step_ff < 5'd9);
            mop.row   = row_of(st4);
            mop.a     = AW_B'(signed'(glob_ff[st4]));
            mop.b     = BW'(b_ff[col_of(st4)]);
         end
         default: begin
            mop = '0;
         end
      endcase
   end

   dfgw_mul u_mul (
      .clock (clock),
      .reset (reset),
      .op    (mop),
      .res   (mres)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff + 5'd1;
      unique case (state_ff)
         dfgw_pkg::ST_IDLE: begin
            step_in = '0;
            if (accept) begin
               unique case (dfgw_pkg::cmd_type'(req_command))
                  dfgw_pkg::CMD_TERM: begin
                     if (node_ok) begin
                        state_in = dfgw_pkg::ST_TERM;
                     end else if (req_last_term) begin
                        state_in = dfgw_pkg::ST_ROUND;
                     end
                  end
                  dfgw_pkg::CMD_PASS: state_in = dfgw_pkg::ST_EMIT;
                  default:            state_in = dfgw_pkg::ST_IDLE;
               endcase
            end
         end
         dfgw_pkg::ST_TERM: begin
            if (step_ff == 5'd16) begin
               state_in = dfgw_pkg::ST_WEIGHT;
               step_in  = '0;
            end
         end
         dfgw_pkg::ST_WEIGHT: begin
            if (step_ff == 5'd3) begin
               state_in = last_ff ? dfgw_pkg::ST_ROUND : dfgw_pkg::ST_IDLE;
               step_in  = '0;
            end
         end
         dfgw_pkg::ST_ROUND: begin
            state_in = apply_ff ? dfgw_pkg::ST_GLOBAL : dfgw_pkg::ST_EMIT;
            step_in  = '0;
         end
         dfgw_pkg::ST_GLOBAL: begin
            if (step_ff == 5'd9) begin
               state_in = dfgw_pkg::ST_SAT;
               step_in  = '0;
            end
         end
         dfgw_pkg::ST_SAT: begin
            state_in = dfgw_pkg::ST_EMIT;
            step_in  = '0;
         end
         dfgw_pkg::ST_EMIT: begin
            step_in = '0;
            if (out_free) begin
               state_in = dfgw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dfgw_pkg::ST_IDLE;
            step_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= dfgw_pkg::ST_IDLE;
         step_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         rd_vld_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      rd_ord_ff <= rd_ord;
   end

   // configuration and global words
   always_ff @(posedge clock) begin
      if (reset) begin
         apply_ff <= 1'b1;
         for (int i = 0; i < dfgw_pkg::GLOBAL_WORDS; i++) begin
            glob_ff[i] <= (i == 0 || i == 4 || i == 8) ? dfgw_pkg::ONE_Q428 : '0;
         end
      end else begin
         if (csr_wr_en) begin
            apply_ff <= csr_wr_data;
         end
         if (accept && (dfgw_pkg::cmd_type'(req_command) == dfgw_pkg::CMD_GLOBAL_WORD)
             && (req_word_select < 4'(dfgw_pkg::GLOBAL_WORDS))) begin
            glob_ff[req_word_select] <= req_word_value;
         end
      end
   end

   // accumulators: weighted blend, saturating at 64 bits, cleared by a pass or a round
   always_ff @(posedge clock) begin
      logic signed [64:0] sum;
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            acc_ff[k] <= '0;
         end
      end else if (accept && (dfgw_pkg::cmd_type'(req_command) == dfgw_pkg::CMD_PASS)) begin
         for (int k = 0; k < 3; k++) begin
            acc_ff[k] <= '0;
         end
      end else if (state_ff == dfgw_pkg::ST_ROUND) begin
         for (int k = 0; k < 3; k++) begin
            acc_ff[k] <= '0;
         end
      end else if ((state_ff == dfgw_pkg::ST_WEIGHT) && mres.valid) begin
         sum = 65'(acc_ff[mres.row]) + 65'(signed'(mres.prod[63:0]));
         if (sum[64] != sum[63]) begin
            acc_ff[mres.row] <= sum[64] ? 64'sh8000_0000_0000_0000
                                        : 64'sh7FFF_FFFF_FFFF_FFFF;
         end else begin
            acc_ff[mres.row] <= sum[63:0];
         end
      end
   end

   // term datapath
   always_ff @(posedge clock) begin
      logic signed [48:0] r16;
      if (accept) begin
         pt_ff[0] <= req_point_x;
         pt_ff[1] <= req_point_y;
         pt_ff[2] <= req_point_z;
         w_ff     <= req_weight;
         last_ff  <= req_last_term;
         base_ff  <= req_base;
      end
      // g and t words, then products of A rows
      if ((state_ff == dfgw_pkg::ST_TERM) && rd_vld_ff) begin
         if (rd_ord_ff >= 4'd9 && rd_ord_ff <= 4'd11) begin
            g_ff[g_idx] <= rd_data;
            d_ff[g_idx] <= 33'(pt_ff[g_idx]) - 33'(signed'(rd_data));
         end else if (rd_ord_ff >= 4'd12) begin
            u_ff[t_idx] <= BW'(g_ff[t_idx]) + BW'(signed'(rd_data));
         end
      end
      if ((state_ff == dfgw_pkg::ST_TERM) && mres.valid) begin
         u_ff[mres.row] <= u_ff[mres.row] + BW'(rp);
      end
      // round the blend, seed the global rows with translation
      if (state_ff == dfgw_pkg::ST_ROUND) begin
         for (int k = 0; k < 3; k++) begin
            r16 = 49'(acc_ff[k] >>> 16) + 49'(acc_ff[k][15]);
            b_ff[k]   <= sat32(r16);
            res_ff[k] <= sat32(r16);
            q_ff[k]   <= BW'(signed'(glob_ff[9 + k]));
         end
         res_def_ff <= 1'b1;
      end
      if ((state_ff == dfgw_pkg::ST_GLOBAL) && mres.valid) begin
         q_ff[mres.row] <= q_ff[mres.row] + BW'(rp);
      end
      if (state_ff == dfgw_pkg::ST_SAT) begin
         for (int k = 0; k < 3; k++) begin
            res_ff[k] <= sat32(49'(q_ff[k]));
         end
      end
      // pass-through point
      if (accept && (dfgw_pkg::cmd_type'(req_command) == dfgw_pkg::CMD_PASS)) begin
         res_ff[0]  <= req_point_x;
         res_ff[1]  <= req_point_y;
         res_ff[2]  <= req_point_z;
         res_def_ff <= 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_x_ff   <= res_ff[0];
         rsp_y_ff   <= res_ff[1];
         rsp_z_ff   <= res_ff[2];
         rsp_def_ff <= res_def_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_x    = rsp_x_ff;
   assign rsp_out_y    = rsp_y_ff;
   assign rsp_out_z    = rsp_z_ff;
   assign rsp_deformed = rsp_def_ff;

   // checks
   a_mul_phase: assert property (@(posedge clock) disable iff (reset)
      mres.valid |-> (state_ff == dfgw_pkg::ST_TERM || state_ff == dfgw_pkg::ST_WEIGHT
                      || state_ff == dfgw_pkg::ST_GLOBAL))
      else $error("multiplier product outside an arithmetic phase");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      emit_load |=> rsp_valid)
      else $error("emitted transaction not presented");

   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dfgw_pkg::ST_ROUND) |=> (acc_ff[0] == '0 && acc_ff[1] == '0
                                            && acc_ff[2] == '0))
      else $error("accumulators not cleared after final term");

endmodule
